### hdl/led_blink_sequencer_assert.svh
`ifndef LED_BLINK_SEQUENCER_ASSERT_SVH
`define LED_BLINK_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LBS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("led_blink_sequencer: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("led_blink_sequencer: assertion failed");

`endif

### hdl/lbs_pkg.sv
package lbs_pkg;

	localparam int COUNT_BITS   = 8;
	localparam int CYCLE_BITS   = 16;
	localparam int ELAPSED_BITS = 16;
	localparam int NEXT_BITS    = 9;

	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_SET   = 2'd1,
		FUNC_BLINK = 2'd2
	} lbs_func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic        level;
		logic [7:0]  blink_count;
		logic [15:0] cycle_ms;
		logic        bias;
		logic        has_handler;
	} lbs_item_t;

	typedef struct packed {
		logic        pin_level;
		logic        callback_pulse;
		logic        blinking;
		logic [15:0] blink_number;
	} lbs_result_t;

	typedef struct packed {
		logic                    steady_level;
		logic [COUNT_BITS-1:0]   blinks_total;
		logic [CYCLE_BITS-1:0]   cycle_length;
		logic                    bias_bit;
		logic                    handler_enabled;
		logic [CYCLE_BITS-1:0]   cycle_position;
		logic [CYCLE_BITS-1:0]   half_position;
		logic                    phase_bit;
		logic [ELAPSED_BITS-1:0] cycles_elapsed;
		logic [NEXT_BITS-1:0]    callbacks_next;
		logic                    started;
		logic                    pin_register;
	} lbs_state_t;

	// Half period in ticks; a cycle length of one still gives one tick.
	function automatic logic [CYCLE_BITS-1:0] half_length(input logic [CYCLE_BITS-1:0] len);
		logic [CYCLE_BITS-1:0] h;
		h = len >> 1;
		return (h == '0) ? CYCLE_BITS'(1) : h;
	endfunction

endpackage

### hdl/led_blink_sequencer.sv
// Datapath: an accepted beat is held in the input register (item_s1), then its result is registered in result_q.
// Throughput: one item per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Reset: arst_n low clears all blink state (steady level low, no run, never
// started) and empties both registers; no clearing pass is needed.
module led_blink_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  lbs_pkg::lbs_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output lbs_pkg::lbs_result_t result
);
	import lbs_pkg::*;

	`include "led_blink_sequencer_assert.svh"

	lbs_item_t   item_s1;
	logic        valid_s1;
	lbs_state_t  state_q;
	lbs_state_t  state_nxt;
	lbs_result_t res_c;
	lbs_result_t result_q;
	logic        result_valid_q;
	logic        advance;

	assign advance      = !result_valid_q || result_ready;
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	lbs_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance)
			result_q <= res_c;
	end

	// Commit state only when the beat moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.steady_level    <= 1'b0;
			state_q.blinks_total    <= '0;
			state_q.cycle_length    <= CYCLE_BITS'(1);
			state_q.bias_bit        <= 1'b0;
			state_q.handler_enabled <= 1'b0;
			state_q.cycle_position  <= '0;
			state_q.half_position   <= '0;
			state_q.phase_bit       <= 1'b0;
			state_q.cycles_elapsed  <= '0;
			state_q.callbacks_next  <= '0;
			state_q.started         <= 1'b0;
			state_q.pin_register    <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	`LBS_ASSERT_NOW(a_run_implies_started, state_q.blinks_total != '0, state_q.started)
	`LBS_ASSERT_NOW(a_pulse_only_in_run, result_valid_q && result_q.callback_pulse,
		result_q.blinking)
	`LBS_ASSERT_NOW(a_blinking_has_number, result_valid_q && result_q.blinking,
		result_q.blink_number != '0)
	`LBS_ASSERT_NOW(a_half_in_range, state_q.started,
		state_q.half_position < half_length(state_q.cycle_length))
	`LBS_ASSERT_NEXT(a_stage_moves, valid_s1 && advance, result_valid_q)

endmodule

### hdl/lbs_step.sv
module lbs_step (
	input  lbs_pkg::lbs_state_t  cur,
	input  lbs_pkg::lbs_item_t   item,
	output lbs_pkg::lbs_state_t  nxt,
	output lbs_pkg::lbs_result_t res
);
	import lbs_pkg::*;

	always_comb begin
		lbs_state_t            s;
		logic                  pulse;
		logic                  do_eval;
		logic [CYCLE_BITS-1:0] hp;
		logic [CYCLE_BITS-1:0] cp;
		logic [COUNT_BITS-1:0] n;
		logic [CYCLE_BITS-1:0] c;

		s       = cur;
		pulse   = 1'b0;
		do_eval = 1'b0;
		hp      = cur.half_position + CYCLE_BITS'(1);
		cp      = cur.cycle_position + CYCLE_BITS'(1);
		n       = COUNT_BITS'(item.blink_count);
		c       = CYCLE_BITS'(item.cycle_ms);

		case (item.func)
			FUNC_TICK: begin
				if (cur.started) begin
					if (hp >= half_length(cur.cycle_length)) begin
						s.half_position = '0;
						s.phase_bit     = ~cur.phase_bit;
					end else begin
						s.half_position = hp;
					end
					if (cp >= cur.cycle_length) begin
						s.cycle_position = '0;
						if (cur.cycles_elapsed != ELAPSED_MAX)
							s.cycles_elapsed = cur.cycles_elapsed + ELAPSED_BITS'(1);
					end else begin
						s.cycle_position = cp;
					end
				end
				do_eval = 1'b1;
			end
			FUNC_SET: begin
				s.steady_level = item.level;
				s.pin_register = item.level;
				s.blinks_total = '0;
			end
			FUNC_BLINK: begin
				s.handler_enabled = 1'b0;
				s.bias_bit        = item.bias;
				s.cycle_position  = '0;
				s.half_position   = '0;
				s.phase_bit       = 1'b0;
				s.cycles_elapsed  = '0;
				s.callbacks_next  = '0;
				if (n == '0 || c == '0) begin
					s.blinks_total = '0;
					s.cycle_length = CYCLE_BITS'(1);
					s.started      = 1'b0;
					s.pin_register = cur.steady_level;
				end else begin
					s.handler_enabled = item.has_handler;
					s.blinks_total    = n;
					s.cycle_length    = c;
					s.started         = 1'b1;
					do_eval           = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// End the run once enough cycles went by, else drive the blink phase and any due callback pulse.
		if (do_eval && s.blinks_total != '0) begin
			if (s.cycles_elapsed >= ELAPSED_BITS'(s.blinks_total)) begin
				s.blinks_total = '0;
				s.pin_register = s.steady_level;
			end else begin
				s.pin_register = (s.phase_bit == s.bias_bit) ? 1'b0 : 1'b1;
				if (s.cycles_elapsed >= ELAPSED_BITS'(s.callbacks_next)) begin
					pulse            = s.handler_enabled;
					s.callbacks_next = NEXT_BITS'(s.cycles_elapsed + ELAPSED_BITS'(1));
				end
			end
		end

		nxt = s;

		res.pin_level      = s.pin_register;
		res.callback_pulse = pulse;
		res.blinking       = (s.blinks_total != '0);
		if (!s.started)
			res.blink_number = '0;
		else if (s.cycles_elapsed != ELAPSED_MAX)
			res.blink_number = 16'(s.cycles_elapsed + ELAPSED_BITS'(1));
		else
			res.blink_number = 16'(ELAPSED_MAX);
	end

endmodule
